// ----- hw/rtl/dtrl_pkg.sv -----
// Package for the DNA trie read lookup block.
// Holds the function and phase codes, the controller/datapath structs and the symbol decoder.
// No dependencies.
`default_nettype none

package dtrl_pkg;

  localparam int unsigned INDEX_BITS_DEF = 12;
  localparam longint unsigned NODE_COUNT_DEF = 64'd4096;

  localparam int unsigned SLOT_COUNT = 5;

  localparam logic [2:0] SLOT_A = 3'd0;
  localparam logic [2:0] SLOT_C = 3'd1;
  localparam logic [2:0] SLOT_G = 3'd2;
  localparam logic [2:0] SLOT_T = 3'd3;
  localparam logic [2:0] SLOT_N = 3'd4;

  localparam logic [7:0] SYM_A = 8'h41;
  localparam logic [7:0] SYM_C = 8'h43;
  localparam logic [7:0] SYM_G = 8'h47;
  localparam logic [7:0] SYM_T = 8'h54;
  localparam logic [7:0] SYM_N = 8'h4e;

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_END    = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    OUT_FOUND  = 2'd0,
    OUT_PREFIX = 2'd1,
    OUT_MISS   = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_FOUND  = 2'd1,
    PH_FAILED = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_WAIT  = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic clr;       // clear one store entry
    logic wr;        // write item accepted
    logic lookup;    // symbol item accepted
    logic finish;    // edge read data is back
    logic end_item;  // end-of-target item accepted
  } dtrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic searching;
    logic out_stall;
  } dtrl_stat_t;

  function automatic logic [2:0] slot_of(logic [7:0] sym);
    logic [2:0] slot;
    unique case (sym)
      SYM_A:   slot = SLOT_A;
      SYM_C:   slot = SLOT_C;
      SYM_G:   slot = SLOT_G;
      SYM_T:   slot = SLOT_T;
      default: slot = SLOT_N;
    endcase
    return slot;
  endfunction

  function automatic logic sym_bad(logic [7:0] sym);
    logic bad;
    unique case (sym)
      SYM_A, SYM_C, SYM_G, SYM_T, SYM_N: bad = 1'b0;
      default:                           bad = 1'b1;
    endcase
    return bad;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dtrl_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module dtrl_ram #(
  parameter int unsigned     WIDTH = 13,
  parameter longint unsigned DEPTH = 64'd20480,
  localparam int unsigned    AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dtrl_ctrl.sv -----
// Controller of the DNA trie read lookup: clear pass, item handshake, lookup wait state.
// Depends on dtrl_pkg.
`default_nettype none

module dtrl_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic [1:0]           func_i,
  output logic                      in_ready_o,
  input  wire dtrl_pkg::dtrl_stat_t stat_i,
  output dtrl_pkg::dtrl_cmd_t       cmd_o
);

  dtrl_pkg::ctrl_state_e state_q, state_d;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtrl_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      dtrl_pkg::ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = dtrl_pkg::ST_IDLE;
        end
      end
      dtrl_pkg::ST_IDLE: begin
        // an end item needs room in the output register
        in_ready_o = !((func_i == dtrl_pkg::FUNC_END) && stat_i.out_stall);
        accept     = in_valid_i && in_ready_o;
        cmd_o.wr       = accept && (func_i == dtrl_pkg::FUNC_WRITE);
        cmd_o.lookup   = accept && (func_i == dtrl_pkg::FUNC_LOOKUP);
        cmd_o.end_item = accept && (func_i == dtrl_pkg::FUNC_END);
        if (cmd_o.lookup && stat_i.searching) begin
          state_d = dtrl_pkg::ST_WAIT;
        end
      end
      dtrl_pkg::ST_WAIT: begin
        cmd_o.finish = 1'b1;
        state_d      = dtrl_pkg::ST_IDLE;
      end
      default: begin
        state_d = dtrl_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dtrl_dpath.sv -----
// Datapath of the DNA trie read lookup: edge store, walk state and output register.
// Depends on dtrl_pkg and dtrl_ram.
`default_nettype none

module dtrl_dpath #(
  parameter int unsigned     INDEX_BITS = dtrl_pkg::INDEX_BITS_DEF,
  parameter longint unsigned NODE_COUNT = dtrl_pkg::NODE_COUNT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dtrl_pkg::dtrl_cmd_t   cmd_i,
  output dtrl_pkg::dtrl_stat_t       stat_o,
  input  wire logic [INDEX_BITS-1:0] node_addr_i,
  input  wire logic [2:0]            edge_slot_i,
  input  wire logic [INDEX_BITS-1:0] edge_target_i,
  input  wire logic                  edge_ends_i,
  input  wire logic [7:0]            symbol_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [1:0]                 outcome_o,
  output logic [INDEX_BITS-1:0]      value_o,
  output logic                       excess_o,
  output logic                       bad_symbol_o
);

  localparam longint unsigned DEPTH = NODE_COUNT * dtrl_pkg::SLOT_COUNT;
  localparam int unsigned     AW    = $clog2(DEPTH);
  localparam int unsigned     EW    = INDEX_BITS + 1;
  localparam int unsigned     SUMW  = INDEX_BITS + 3;

  function automatic logic [AW-1:0] edge_addr(logic [INDEX_BITS-1:0] node, logic [2:0] slot);
    logic [SUMW-1:0] sum;
    sum = (SUMW'(node) << 2) + SUMW'(node) + SUMW'(slot);
    return AW'(sum);
  endfunction

  function automatic logic node_ok(logic [INDEX_BITS-1:0] node);
    return 64'(node) < NODE_COUNT;
  endfunction

  logic [AW-1:0]         clr_cnt_q;
  logic [INDEX_BITS-1:0] node_q;
  dtrl_pkg::phase_e      phase_q;
  logic [INDEX_BITS-1:0] found_q;
  logic                  excess_q;
  logic                  bad_q;
  logic                  pend_bad_q;
  logic                  pend_ok_q;
  logic                  out_valid_q;
  dtrl_pkg::outcome_e    outcome_q;
  logic [INDEX_BITS-1:0] value_q;
  logic                  out_excess_q;
  logic                  out_bad_q;

  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [EW-1:0]         ram_wdata;
  logic [EW-1:0]         ram_rdata;
  logic [EW-1:0]         edge_w;
  logic [INDEX_BITS-1:0] edge_tgt;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {edge_ends_i, edge_target_i};
    priority if (cmd_i.clr) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_q;
      ram_wdata = '0;
    end else if (cmd_i.wr) begin
      ram_we   = node_ok(node_addr_i) && (edge_slot_i <= dtrl_pkg::SLOT_N);
      ram_addr = edge_addr(node_addr_i, edge_slot_i);
    end else begin
      ram_addr = edge_addr(node_q, dtrl_pkg::slot_of(symbol_i));
    end
  end

  dtrl_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // an out-of-range node reads as all edges empty
  assign edge_w   = pend_ok_q ? ram_rdata : '0;
  assign edge_tgt = edge_w[INDEX_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q     <= INDEX_BITS'(1);
      phase_q    <= dtrl_pkg::PH_SEARCH;
      found_q    <= '0;
      excess_q   <= 1'b0;
      bad_q      <= 1'b0;
      pend_bad_q <= 1'b0;
      pend_ok_q  <= 1'b0;
    end else if (cmd_i.end_item) begin
      node_q   <= INDEX_BITS'(1);
      phase_q  <= dtrl_pkg::PH_SEARCH;
      found_q  <= '0;
      excess_q <= 1'b0;
      bad_q    <= 1'b0;
    end else if (cmd_i.lookup) begin
      if (phase_q == dtrl_pkg::PH_SEARCH) begin
        pend_bad_q <= dtrl_pkg::sym_bad(symbol_i);
        pend_ok_q  <= node_ok(node_q);
      end else if (phase_q == dtrl_pkg::PH_FOUND) begin
        excess_q <= 1'b1;
      end
    end else if (cmd_i.finish) begin
      bad_q <= bad_q | pend_bad_q;
      priority if (edge_tgt == '0) begin
        phase_q <= dtrl_pkg::PH_FAILED;
      end else if (edge_w[INDEX_BITS]) begin
        phase_q <= dtrl_pkg::PH_FOUND;
        found_q <= edge_tgt;
      end else begin
        node_q <= edge_tgt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.end_item) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.end_item) begin
      out_excess_q <= excess_q;
      out_bad_q    <= bad_q;
      unique case (phase_q)
        dtrl_pkg::PH_FOUND: begin
          outcome_q <= dtrl_pkg::OUT_FOUND;
          value_q   <= found_q;
        end
        dtrl_pkg::PH_SEARCH: begin
          outcome_q <= dtrl_pkg::OUT_PREFIX;
          value_q   <= node_q;
        end
        default: begin
          outcome_q <= dtrl_pkg::OUT_MISS;
          value_q   <= '0;
        end
      endcase
    end
  end

  assign stat_o.clr_last  = (clr_cnt_q == AW'(DEPTH - 64'd1));
  assign stat_o.searching = (phase_q == dtrl_pkg::PH_SEARCH);
  assign stat_o.out_stall = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign outcome_o    = outcome_q;
  assign value_o      = value_q;
  assign excess_o     = out_excess_q;
  assign bad_symbol_o = out_bad_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dna_trie_read_lookup.sv -----
// Top level of the DNA trie read lookup.
// Depends on dtrl_pkg, dtrl_ctrl, dtrl_dpath (and dtrl_ram below it).
//
// Usage:
//  - One input channel (in_valid_i/in_ready_o) carries write, lookup and end items;
//    one output channel (out_valid_o/out_ready_i) carries one result per end item.
//  - A write item stores one edge (end flag and target) of a node.
//  - A lookup item consumes one symbol of the target. While the walk is still
//    searching, the item issues the edge store read and the wait state that
//    follows takes the registered read data and moves the walk. After the walk
//    has ended a lookup item needs no store read.
//  - An end item's result is in the output register on the next
//    cycle and the walk restarts at root node 1.
//  - The output register holds one result. While it waits on out_ready_i, writes
//    and lookups are still taken; a further end item waits until the register frees.
//  - After reset the edge store is cleared one entry per cycle, all 5 * NODE_COUNT
//    entries (20480 at the defaults); in_ready_o stays low during that pass.
`default_nettype none

module dna_trie_read_lookup #(
  parameter int unsigned     INDEX_BITS = dtrl_pkg::INDEX_BITS_DEF,
  parameter longint unsigned NODE_COUNT = dtrl_pkg::NODE_COUNT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            func_i,
  input  wire logic [INDEX_BITS-1:0] node_addr_i,
  input  wire logic [2:0]            edge_slot_i,
  input  wire logic [INDEX_BITS-1:0] edge_target_i,
  input  wire logic                  edge_ends_i,
  input  wire logic [7:0]            symbol_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [1:0]                 outcome_o,
  output logic [INDEX_BITS-1:0]      value_o,
  output logic                       excess_o,
  output logic                       bad_symbol_o
);

  dtrl_pkg::dtrl_cmd_t  cmd;
  dtrl_pkg::dtrl_stat_t stat;

  dtrl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dtrl_dpath #(
    .INDEX_BITS (INDEX_BITS),
    .NODE_COUNT (NODE_COUNT)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .node_addr_i   (node_addr_i),
    .edge_slot_i   (edge_slot_i),
    .edge_target_i (edge_target_i),
    .edge_ends_i   (edge_ends_i),
    .symbol_i      (symbol_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .outcome_o     (outcome_o),
    .value_o       (value_o),
    .excess_o      (excess_o),
    .bad_symbol_o  (bad_symbol_o)
  );

  // no item enters while the store is being cleared
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |-> !in_ready_o)
    else $error("item accepted during clear pass");

  // a searching lookup always gets its read data back in the next cycle
  a_lookup_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.lookup && stat.searching) |=> cmd.finish)
    else $error("lookup read not completed");

  // the store port is busy with the returning read, so nothing new enters
  a_finish_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !in_ready_o)
    else $error("item accepted while lookup in flight");

  // every end item shows up as a result
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.end_item |=> out_valid_o)
    else $error("end item produced no result");

endmodule

`default_nettype wire

// ----- bench/tb_dna_trie_read_lookup.sv -----
// Testbench for dna_trie_read_lookup: builds tries with edge writes, walks them with
// symbol items and checks every end-of-target result against a local trie walker.
// Depends on dtrl_pkg and the dna_trie_read_lookup RTL.
`default_nettype none

module tb_dna_trie_read_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NODES        = 4096;
  localparam int          ITEM_TARGET  = 1800;
  localparam int          QUIET_FROM   = 1600;
  localparam int          STALL_LIMIT  = 100000;
  localparam int          LONG_HOLD    = 300;
  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
  localparam logic [2:0]  SLOT_BAD_LO  = 3'd5;
  localparam logic [2:0]  SLOT_BAD_HI  = 3'd7;
  localparam logic [11:0] ROOT         = 12'd1;

  typedef struct {
    dtrl_pkg::outcome_e outcome;
    logic [11:0]        value;
    logic               excess;
    logic               bad;
  } walk_result_t;

  class trie_walk_scoreboard;
    logic [12:0]       edge_mem [0:NODES*dtrl_pkg::SLOT_COUNT-1];
    logic [11:0]       walk_node;
    dtrl_pkg::phase_e  walk_phase;
    logic [11:0]       read_id;
    logic              excess_seen;
    logic              bad_seen;
    walk_result_t      result_q[$];
    int                errors;
    int                checked;
    int                outcome_count[3];

    function new();
      foreach (edge_mem[i]) edge_mem[i] = '0;
      errors = 0;
      checked = 0;
      foreach (outcome_count[i]) outcome_count[i] = 0;
      restart_walk();
    endfunction

    function void restart_walk();
      walk_node   = ROOT;
      walk_phase  = dtrl_pkg::PH_SEARCH;
      read_id     = '0;
      excess_seen = 1'b0;
      bad_seen    = 1'b0;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function void note_item(logic [1:0] func, logic [11:0] node, logic [2:0] slot,
                            logic [11:0] target, logic ends, logic [7:0] sym);
      logic [12:0]  edge_word;
      logic [2:0]   s;
      logic         bad;
      walk_result_t r;
      case (func)
        dtrl_pkg::FUNC_WRITE: begin
          if (slot < dtrl_pkg::SLOT_COUNT)
            edge_mem[int'(node) * dtrl_pkg::SLOT_COUNT + int'(slot)] = {ends, target};
        end
        dtrl_pkg::FUNC_LOOKUP: begin
          if (walk_phase == dtrl_pkg::PH_SEARCH) begin
            bad = 1'b0;
            case (sym)
              dtrl_pkg::SYM_A: s = dtrl_pkg::SLOT_A;
              dtrl_pkg::SYM_C: s = dtrl_pkg::SLOT_C;
              dtrl_pkg::SYM_G: s = dtrl_pkg::SLOT_G;
              dtrl_pkg::SYM_T: s = dtrl_pkg::SLOT_T;
              dtrl_pkg::SYM_N: s = dtrl_pkg::SLOT_N;
              default: begin
                s = dtrl_pkg::SLOT_N;
                bad = 1'b1;
              end
            endcase
            edge_word = edge_mem[int'(walk_node) * dtrl_pkg::SLOT_COUNT + int'(s)];
            if (bad) bad_seen = 1'b1;
            if (edge_word[11:0] == '0) begin
              walk_phase = dtrl_pkg::PH_FAILED;
            end else if (edge_word[12]) begin
              walk_phase = dtrl_pkg::PH_FOUND;
              read_id = edge_word[11:0];
            end else begin
              walk_node = edge_word[11:0];
            end
          end else if (walk_phase == dtrl_pkg::PH_FOUND) begin
            excess_seen = 1'b1;
          end
        end
        dtrl_pkg::FUNC_END: begin
          case (walk_phase)
            dtrl_pkg::PH_FOUND: begin
              r.outcome = dtrl_pkg::OUT_FOUND;
              r.value = read_id;
            end
            dtrl_pkg::PH_SEARCH: begin
              r.outcome = dtrl_pkg::OUT_PREFIX;
              r.value = walk_node;
            end
            default: begin
              r.outcome = dtrl_pkg::OUT_MISS;
              r.value = '0;
            end
          endcase
          r.excess = excess_seen;
          r.bad = bad_seen;
          result_q.push_back(r);
          outcome_count[int'(r.outcome)]++;
          restart_walk();
        end
        default: ;
      endcase
    endfunction

    task check_result(logic [1:0] outcome, logic [11:0] value, logic excess,
                      logic bad);
      walk_result_t r;
      if (result_q.size() == 0) begin
        report($sformatf("result with nothing pending (outcome %0d value %0d)",
                         outcome, value));
        return;
      end
      r = result_q.pop_front();
      checked++;
      if (outcome !== r.outcome)
        report($sformatf("outcome %0d, want %0d", outcome, r.outcome));
      if (value !== r.value)
        report($sformatf("value %0d, want %0d", value, r.value));
      if (excess !== r.excess)
        report($sformatf("excess %0b, want %0b", excess, r.excess));
      if (bad !== r.bad)
        report($sformatf("bad_symbol %0b, want %0b", bad, r.bad));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = dtrl_pkg::FUNC_WRITE;
  logic [11:0] node_addr_i = '0;
  logic [2:0]  edge_slot_i = '0;
  logic [11:0] edge_target_i = '0;
  logic        edge_ends_i = 1'b0;
  logic [7:0]  symbol_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  outcome_o;
  logic [11:0] value_o;
  logic        excess_o;
  logic        bad_symbol_o;

  trie_walk_scoreboard sb;
  int   items_sent = 0;
  bit   quiet = 1'b0;
  bit   send_gaps = 1'b1;
  bit   long_hold_req = 1'b0;

  dna_trie_read_lookup dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .node_addr_i  (node_addr_i),
    .edge_slot_i  (edge_slot_i),
    .edge_target_i(edge_target_i),
    .edge_ends_i  (edge_ends_i),
    .symbol_i     (symbol_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .outcome_o    (outcome_o),
    .value_o      (value_o),
    .excess_o     (excess_o),
    .bad_symbol_o (bad_symbol_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // called at a rising edge, returns at the edge where the item is taken
  task automatic send_item(logic [1:0] func, logic [11:0] node, logic [2:0] slot,
                           logic [11:0] target, logic ends, logic [7:0] sym);
    if (items_sent % 64 == 0) send_gaps = ($urandom_range(0, 3) != 0);
    if (!quiet && send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= func;
    node_addr_i   <= node;
    edge_slot_i   <= slot;
    edge_target_i <= target;
    edge_ends_i   <= ends;
    symbol_i      <= sym;
    // inputs and ready are settled by the falling edge
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_item(func, node, slot, target, ends, sym);
    items_sent++;
    if (items_sent >= QUIET_FROM) quiet = 1'b1;
  endtask

  task automatic send_edge(logic [11:0] node, logic [2:0] slot, logic [11:0] target,
                           logic ends);
    send_item(dtrl_pkg::FUNC_WRITE, node, slot, target, ends, 8'($urandom));
  endtask

  task automatic send_lookup(logic [7:0] sym);
    send_item(dtrl_pkg::FUNC_LOOKUP, 12'($urandom), 3'($urandom), 12'($urandom),
              1'($urandom), sym);
  endtask

  task automatic send_end();
    send_item(dtrl_pkg::FUNC_END, 12'($urandom), 3'($urandom), 12'($urandom),
              1'($urandom), 8'($urandom));
  endtask

  function automatic logic [7:0] letter_of(int s);
    case (s)
      0:       return dtrl_pkg::SYM_A;
      1:       return dtrl_pkg::SYM_C;
      2:       return dtrl_pkg::SYM_G;
      3:       return dtrl_pkg::SYM_T;
      default: return dtrl_pkg::SYM_N;
    endcase
  endfunction

  // mostly a small pool so that walks revisit nodes
  function automatic logic [11:0] pick_node();
    if ($urandom_range(0, 7) == 0) return 12'($urandom_range(2, NODES - 1));
    return 12'($urandom_range(2, 120));
  endfunction

  task automatic run_target();
    int          len;
    int          s;
    int          k;
    logic [12:0] edge_word;
    logic [7:0]  sym;
    if ($urandom_range(0, 9) == 0) begin
      // noise: anything the fields allow, unused function code included
      repeat ($urandom_range(1, 4))
        send_item(2'($urandom), 12'($urandom), 3'($urandom), 12'($urandom),
                  1'($urandom), 8'($urandom));
      return;
    end
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 8);
    repeat (len) begin
      s = $urandom_range(0, 4);
      if (sb.walk_phase == dtrl_pkg::PH_SEARCH) begin
        // usually follow a live edge so the walk goes deep
        if ($urandom_range(0, 3) != 0) begin
          for (k = 0; k < 5; k++) begin
            edge_word = sb.edge_mem[int'(sb.walk_node) * dtrl_pkg::SLOT_COUNT
                                    + (s + k) % 5];
            if (edge_word[11:0] != '0) begin
              s = (s + k) % 5;
              break;
            end
          end
        end
        edge_word = sb.edge_mem[int'(sb.walk_node) * dtrl_pkg::SLOT_COUNT + s];
        if (edge_word[11:0] == '0 && $urandom_range(0, 1) == 0) begin
          if ($urandom_range(0, 3) == 0)
            send_edge(sb.walk_node, 3'(s), 12'($urandom_range(1, NODES - 1)), 1'b1);
          else
            send_edge(sb.walk_node, 3'(s), pick_node(), 1'b0);
        end
      end
      // stray write in the middle of a walk, sometimes removing an edge
      if ($urandom_range(0, 19) == 0)
        send_edge(pick_node(), 3'($urandom_range(0, 4)),
                  ($urandom_range(0, 3) == 0) ? 12'd0 : pick_node(), 1'($urandom));
      sym = ($urandom_range(0, 15) == 0) ? 8'($urandom) : letter_of(s);
      send_lookup(sym);
    end
    send_end();
  endtask

  // receiver: short random stalls, one long hold-off to back the block up
  initial begin
    int  hold_left;
    bit  rx_gaps;
    hold_left = 0;
    rx_gaps = 1'b1;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 199) == 0) rx_gaps = ($urandom_range(0, 3) != 0);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet && rx_gaps && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(1, 6) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // outputs are stable at the falling edge; the item is taken at the next rising edge
  always @(negedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.check_result(outcome_o, value_o, excess_o, bad_symbol_o);
  end

  // watchdog on cycles where neither side moves an item
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("[%0t] stalled for %0d cycles", $realtime, STALL_LIMIT);
    $display("tb_dna_trie_read_lookup: done, errors");
    $finish;
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty target reports the root
    send_end();
    // extremes of node index, target and the end flag
    send_edge(ROOT, dtrl_pkg::SLOT_A, 12'd4095, 1'b0);
    send_edge(12'd4095, dtrl_pkg::SLOT_N, 12'd4095, 1'b1);
    send_edge(12'd0, dtrl_pkg::SLOT_T, 12'd7, 1'b0);
    // slots past N are dropped, as is the unused function code
    send_edge(ROOT, SLOT_BAD_HI, 12'habc, 1'b1);
    send_edge(ROOT, SLOT_BAD_LO, 12'h123, 1'b0);
    send_item(FUNC_UNUSED, 12'hfff, SLOT_BAD_HI, 12'hfff, 1'b1, 8'hff);
    // found, then symbols past the end of the read
    send_lookup(dtrl_pkg::SYM_A);
    send_lookup(dtrl_pkg::SYM_N);
    send_lookup(dtrl_pkg::SYM_G);
    send_end();
    // unknown symbol takes the N edge and flags it
    send_lookup(dtrl_pkg::SYM_A);
    send_lookup(8'hff);
    send_end();
    // prefix at an inner node
    send_lookup(dtrl_pkg::SYM_A);
    send_end();
    // miss, and a later unknown symbol is ignored
    send_lookup(dtrl_pkg::SYM_C);
    send_lookup(8'h00);
    send_end();
    // an edge written mid-walk is used by the same walk
    send_lookup(dtrl_pkg::SYM_A);
    send_edge(12'd4095, dtrl_pkg::SLOT_T, 12'd2, 1'b0);
    send_lookup(dtrl_pkg::SYM_T);
    send_end();

    long_hold_req = 1'b1;
    while (items_sent < ITEM_TARGET) run_target();
    in_valid_i <= 1'b0;

    while (sb.result_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("%0d items driven, %0d walk results checked", items_sent, sb.checked);
    $display("outcomes: %0d found, %0d prefix, %0d miss", sb.outcome_count[0],
             sb.outcome_count[1], sb.outcome_count[2]);
    if (sb.errors == 0 && sb.result_q.size() == 0) begin
      $display("tb_dna_trie_read_lookup: done, clean");
    end else begin
      $display("tb_dna_trie_read_lookup: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
